[sv/modular_exponentiation_top_assert.svh]
// Assertion macros shared by the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular exponentiation: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular exponentiation: next-cycle check failed");

`endif

[sv/mexp_pkg.sv]
`default_nettype none

package mexp_pkg;

  // Width of the arithmetic; the fields are masked or extended to it.
  localparam int unsigned OPERAND_WIDTH = 32;
  // Fixed width of every data field on the channels.
  localparam int unsigned FIELD_WIDTH = 32;
  // Bit counter width: counts OPERAND_WIDTH-1 down to zero.
  localparam int unsigned CNT_WIDTH = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [FIELD_WIDTH-1:0]   field_t;
  typedef logic [CNT_WIDTH-1:0]     count_t;

  // Status of the serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

`default_nettype wire

[sv/mexp_in_if.sv]
`default_nettype none

// Input channel: one beat carries base, exponent and modulus.
interface mexp_in_if import mexp_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t base_value;
  field_t exponent_value;
  field_t modulus_value;

  modport source (output valid, output base_value, output exponent_value,
                  output modulus_value, input ready);
  modport sink (input valid, input base_value, input exponent_value,
                input modulus_value, output ready);
endinterface

`default_nettype wire

[sv/mexp_out_if.sv]
`default_nettype none

// Output channel: one beat carries the power and the error flag.
interface mexp_out_if import mexp_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t power_result;
  logic   modulus_error;

  modport source (output valid, output power_result, output modulus_error,
                  input ready);
  modport sink (input valid, input power_result, input modulus_error,
                output ready);
endinterface

`default_nettype wire

[sv/modular_exponentiation_top.sv]
// Channel | Direction | Beat contents
// in_i    | sink      | base_value, exponent_value, modulus_value
// out_o   | source    | power_result, modulus_error
//
// The base is reduced first, then every exponent bit costs one squaring plus one
// multiply when set, each a pass through the single bit-serial modular multiplier.
// A zero modulus skips the multiplier and goes straight to the output.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
// A result waiting on a stalled output holds in the output register while the
// next item is accepted; that item waits at its end until the register frees.
`default_nettype none

module modular_exponentiation_top import mexp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mexp_in_if.sink           in_i,
  mexp_out_if.source        out_o
);

`include "modular_exponentiation_top_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_OUT
  } state_e;

  state_e   state_q;
  logic     start_q;
  count_t   ecnt_q;
  logic     out_valid_q;
  operand_t acc_q;
  operand_t pw_q;
  operand_t exp_q;
  operand_t m_q;
  logic     err_q;
  field_t   out_result_q;
  logic     out_err_q;

  logic     in_ready;
  logic     accept;
  logic     load_out;
  logic     start_d;
  operand_t m_in;
  logic     m_zero;
  operand_t mul_a;
  operand_t mul_b;
  operand_t product;
  mul_sts_t mul_sts;

  // Handshake strobes, the multiplier start and the masked modulus of the incoming beat.
  always_comb begin
    in_ready = (state_q == S_IDLE);
    accept   = in_i.valid && in_ready;
    load_out = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
    m_in     = operand_t'(in_i.modulus_value);
    m_zero   = (m_in == '0);
    // A new pass starts after a nonzero-modulus beat and after every pass but the last.
    start_d  = (accept && !m_zero) ||
               (mul_sts.done && !(state_q == S_SQR && ecnt_q == '0));
  end

  // Operand selection: reduce the base, multiply into the result, or square.
  always_comb begin
    case (state_q)
      S_REDUCE: begin
        mul_a = operand_t'(1);
        mul_b = pw_q;
      end
      S_MUL: begin
        mul_a = acc_q;
        mul_b = pw_q;
      end
      default: begin
        mul_a = pw_q;
        mul_b = pw_q;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .m_i       (m_q),
    .product_o (product),
    .sts_o     (mul_sts)
  );

  // Sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= start_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (m_zero) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_REDUCE;
              ecnt_q  <= count_t'(OPERAND_WIDTH - 1);
            end
          end
        end
        S_REDUCE: begin
          if (mul_sts.done) begin
            state_q <= exp_q[0] ? S_MUL : S_SQR;
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_sts.done) begin
            if (ecnt_q == '0) begin
              state_q <= S_OUT;
            end else begin
              ecnt_q  <= ecnt_q - count_t'(1);
              state_q <= exp_q[1] ? S_MUL : S_SQR;
            end
          end
        end
        S_OUT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q   <= m_in;
      pw_q  <= operand_t'(in_i.base_value);
      exp_q <= operand_t'(in_i.exponent_value);
      acc_q <= (m_in == operand_t'(1)) ? '0 : operand_t'(1);
      err_q <= m_zero;
    end
    if (mul_sts.done) begin
      case (state_q)
        S_REDUCE: pw_q <= product;
        S_MUL:    acc_q <= product;
        S_SQR: begin
          pw_q  <= product;
          exp_q <= exp_q >> 1;
        end
        default: begin
        end
      endcase
    end
    if (load_out) begin
      out_result_q <= err_q ? '0 : field_t'(acc_q);
      out_err_q    <= err_q;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.power_result  = out_result_q;
  assign out_o.modulus_error = out_err_q;

  // A zero-modulus beat goes straight to the output without a multiply.
  `MEXP_ASSERT_NEXT(a_zero_mod_skips_mul, clk_i, rst_ni, accept && m_zero,
                    state_q == S_OUT && !start_q)
  // The multiplier is only started when it is free.
  `MEXP_ASSERT_SAME(a_start_when_free, clk_i, rst_ni, start_q, !mul_sts.busy)
  // A finished product only arrives while a multiply step is pending.
  `MEXP_ASSERT_SAME(a_done_in_step, clk_i, rst_ni, mul_sts.done,
                    state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR)
  // An error result always carries a zero power.
  `MEXP_ASSERT_SAME(a_error_zero, clk_i, rst_ni, out_valid_q && out_err_q,
                    out_result_q == '0)

endmodule

`default_nettype wire

[sv/mexp_mulmod.sv]
`default_nettype none

// Serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
// Requires a < m and m nonzero; b may be any value, so a = 1 reduces b.
module mexp_mulmod import mexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  operand_t a_i,
  input  operand_t b_i,
  input  operand_t m_i,
  output operand_t product_o,
  output mul_sts_t sts_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  count_t                 cnt_q, cnt_d;
  operand_t               acc_q, acc_d;
  operand_t               b_q, b_d;
  logic [OPERAND_WIDTH:0] dbl_sum;
  logic [OPERAND_WIDTH:0] add_sum;
  logic [OPERAND_WIDTH:0] m_ext;
  operand_t               dbl_red;
  operand_t               add_red;

  // One step: double the accumulator mod m, then add a mod m if the bit is set.
  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl_sum = {1'b0, acc_q} + {1'b0, acc_q};
    dbl_red = (dbl_sum >= m_ext) ? operand_t'(dbl_sum - m_ext) : operand_t'(dbl_sum);
    add_sum = {1'b0, dbl_red} + {1'b0, a_i};
    add_red = (add_sum >= m_ext) ? operand_t'(add_sum - m_ext) : operand_t'(add_sum);
  end

  // Next values of the counter and the data shift registers.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = count_t'(OPERAND_WIDTH - 1);
      acc_d  = '0;
      b_d    = b_i;
    end else if (busy_q) begin
      acc_d = b_q[OPERAND_WIDTH-1] ? add_red : dbl_red;
      b_d   = {b_q[OPERAND_WIDTH-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - count_t'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign product_o  = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire
